FILE: design/ecg_delta_rle_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// ECG delta / run-length decoder assertion macros
// Short forms for the concurrent checks kept at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ECG_DELTA_RLE_STREAM_DECODER_ASSERT_SVH
`define ECG_DELTA_RLE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ECG_DRLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ECG_DRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ecg_drle_pkg.sv
// ----------------------------------------------------------------------------
// ECG delta / run-length decoder package
// Widths, configuration types and result word shared by the decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package ecg_drle_pkg;

   // Widest field that the bit stream can carry.
   localparam int MAX_FIELD_BITS = 16;

   localparam int ACC_W    = MAX_FIELD_BITS;
   localparam int IDX_W    = $clog2(ACC_W);
   localparam int CNT_W    = $clog2(MAX_FIELD_BITS + 1);
   localparam int REF_W    = MAX_FIELD_BITS + 2;
   localparam int FLAG_W   = 16;
   localparam int CMP_W    = (ACC_W > FLAG_W) ? ACC_W : FLAG_W;
   localparam int CFG_WW   = 5;
   localparam int SAMPLE_W = 19;
   localparam int REPEAT_W = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BITS_ORIGINAL  = 3'd0,
      CSR_BITS_SCALED    = 3'd1,
      CSR_BITS_THRESHOLD = 3'd2,
      CSR_LOSSY_ENABLED  = 3'd3,
      CSR_FLAG_VALUE     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WW-1:0]        bits_original;
      logic [CFG_WW-1:0]        bits_scaled;
      logic [CFG_WW-1:0]        bits_threshold;
      logic                     lossy_enabled;
      logic signed [FLAG_W-1:0] flag_value;
   } cfg_type;

   localparam logic [CFG_WW-1:0]        BITS_ORIGINAL_RST  = CFG_WW'(11);
   localparam logic [CFG_WW-1:0]        BITS_SCALED_RST    = CFG_WW'(8);
   localparam logic [CFG_WW-1:0]        BITS_THRESHOLD_RST = CFG_WW'(4);
   localparam logic signed [FLAG_W-1:0] FLAG_VALUE_RST     = -FLAG_W'(8);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [REPEAT_W-1:0]        repeat_res;
      logic                       stream_end;
      logic                       truncated;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_push_type;

   // Field width as the decoder uses it: zero acts as one, large values saturate.
   function automatic logic [CNT_W-1:0] clamp_width(input logic [CFG_WW-1:0] r);
      logic [CNT_W-1:0] w;
      if (r == '0) begin
         w = CNT_W'(1);
      end else if (int'(r) > MAX_FIELD_BITS) begin
         w = CNT_W'(MAX_FIELD_BITS);
      end else begin
         w = CNT_W'(r);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: design/ecg_drle_req_if.sv
// ----------------------------------------------------------------------------
// ECG decoder input channel
// One stream bit per word, with a flag on the final bit of the payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecg_drle_req_if;
   logic valid;
   logic ready;
   logic bit_req;
   logic last;

   modport source (output valid, output bit_req, output last, input ready);
   modport sink   (input valid, input bit_req, input last, output ready);
endinterface

`default_nettype wire

FILE: design/ecg_drle_rsp_if.sv
// ----------------------------------------------------------------------------
// ECG decoder result channel
// One reconstructed sample with its run length and end flags per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecg_drle_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [ecg_drle_pkg::SAMPLE_W-1:0] sample;
   logic [ecg_drle_pkg::REPEAT_W-1:0]        repeat_res;
   logic                                     stream_end;
   logic                                     truncated;

   modport source (output valid, output sample, output repeat_res, output stream_end,
                   output truncated, input ready);
   modport sink   (input valid, input sample, input repeat_res, input stream_end,
                   input truncated, output ready);
endinterface

`default_nettype wire

FILE: design/ecg_drle_csr_if.sv
// ----------------------------------------------------------------------------
// ECG decoder configuration channel
// Register write port: register index and write data per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecg_drle_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [ecg_drle_pkg::CSR_IDX_W-1:0]    reg_index;
   logic [ecg_drle_pkg::CSR_DATA_W-1:0]   wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

FILE: design/ecg_drle_core.sv
// ----------------------------------------------------------------------------
// ECG decoder bit parser
// Field assembly, token decode, sample rebuild; one bit per accepted cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecg_drle_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  bit_req,
   input  wire logic                  last,
   input  wire ecg_drle_pkg::cfg_type cfg,
   output ecg_drle_pkg::rsp_push_type push
);
   import ecg_drle_pkg::*;

   typedef enum logic [2:0] {
      PH_DESIG,
      PH_FIRST,
      PH_TOKEN,
      PH_SCALED,
      PH_COUNT
   } phase_type;

   phase_type          phase_ff,   phase_in;
   logic [ACC_W-1:0]   acc_ff,     acc_in;
   logic [CNT_W-1:0]   cnt_ff,     cnt_in;
   logic [ACC_W-1:0]   desig_ff,   desig_in;
   logic [REF_W-1:0]   ref_ff,     ref_in;
   logic [ACC_W-1:0]   pend_ff,    pend_in;

   logic [CNT_W-1:0]          fw;
   logic [CNT_W-1:0]          cnt_next;
   logic [ACC_W-1:0]          acc_shift;
   logic [ACC_W-1:0]          fmask;
   logic [ACC_W-1:0]          fval;
   logic [IDX_W-1:0]          sign_idx;
   logic [ACC_W-1:0]          tok;
   logic signed [CMP_W-1:0]   tok_cmp;
   logic signed [CMP_W-1:0]   flag_cmp;
   logic [REF_W-1:0]          scaled_sum;
   logic [SAMPLE_W-1:0]       err_sum;
   logic [SAMPLE_W-1:0]       run_sum;
   logic [ACC_W:0]            run_full;
   rsp_word_type              trunc_word;

   // Width of the field now being collected.
   always_comb begin
      case (phase_ff)
         PH_FIRST, PH_SCALED: fw = clamp_width(cfg.bits_scaled);
         PH_TOKEN, PH_COUNT:  fw = clamp_width(cfg.bits_threshold);
         default:             fw = clamp_width(cfg.bits_original);
      endcase
   end

   // Field value and its arithmetic, all from the current bit.
   always_comb begin
      acc_shift = {acc_ff[ACC_W-2:0], bit_req};
      cnt_next  = cnt_ff + CNT_W'(1);
      for (int i = 0; i < ACC_W; i++) begin
         fmask[i] = (i < int'(fw));
      end
      fval       = acc_shift & fmask;
      sign_idx   = IDX_W'(fw - CNT_W'(1));
      tok        = fval[sign_idx] ? (fval | ~fmask) : fval;
      tok_cmp    = CMP_W'($signed(tok));
      flag_cmp   = CMP_W'($signed(cfg.flag_value));
      scaled_sum = REF_W'(fval) + REF_W'(desig_ff);
      err_sum    = SAMPLE_W'(ref_ff) + SAMPLE_W'($signed(tok));
      run_sum    = SAMPLE_W'(ref_ff) + SAMPLE_W'($signed(pend_ff));
      run_full   = (fval == '0) ? ((ACC_W+1)'(1) << fw) : (ACC_W+1)'(fval);
      trunc_word = '{sample: '0, repeat_res: '0, stream_end: 1'b1, truncated: 1'b1};
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      desig_in = desig_ff;
      ref_in   = ref_ff;
      pend_in  = pend_ff;
      push     = '0;

      if (accept) begin
         acc_in = acc_shift;
         cnt_in = cnt_next;
         if (cnt_next < fw) begin
            if (last) begin
               push = '{valid: 1'b1, word: trunc_word};
            end
         end else begin
            acc_in = '0;
            cnt_in = '0;
            case (phase_ff)
               PH_FIRST, PH_SCALED: begin
                  ref_in   = scaled_sum;
                  phase_in = PH_TOKEN;
                  push.valid           = 1'b1;
                  push.word.sample     = SAMPLE_W'(scaled_sum);
                  push.word.repeat_res = REPEAT_W'(1);
                  push.word.stream_end = last;
               end
               PH_TOKEN: begin
                  if (tok_cmp == flag_cmp) begin
                     phase_in = PH_SCALED;
                     if (last) begin
                        push = '{valid: 1'b1, word: trunc_word};
                     end
                  end else if (cfg.lossy_enabled) begin
                     pend_in  = tok;
                     phase_in = PH_COUNT;
                     if (last) begin
                        push = '{valid: 1'b1, word: trunc_word};
                     end
                  end else begin
                     push.valid           = 1'b1;
                     push.word.sample     = err_sum;
                     push.word.repeat_res = REPEAT_W'(1);
                     push.word.stream_end = last;
                  end
               end
               PH_COUNT: begin
                  pend_in  = '0;
                  phase_in = PH_TOKEN;
                  push.valid           = 1'b1;
                  push.word.sample     = run_sum;
                  push.word.repeat_res = REPEAT_W'(run_full);
                  push.word.stream_end = last;
               end
               default: begin
                  desig_in = fval;
                  phase_in = PH_FIRST;
                  if (last) begin
                     push = '{valid: 1'b1, word: trunc_word};
                  end
               end
            endcase
         end

         // A result that closes the stream starts a fresh one.
         if (push.valid && push.word.stream_end) begin
            phase_in = PH_DESIG;
            acc_in   = '0;
            cnt_in   = '0;
            desig_in = '0;
            ref_in   = '0;
            pend_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DESIG;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         desig_ff <= '0;
         ref_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         desig_ff <= desig_in;
         ref_ff   <= ref_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/ecg_drle_rsp_buf.sv
// ----------------------------------------------------------------------------
// ECG decoder result buffer
// Output register plus skid entry; input bits keep flowing until both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module ecg_drle_rsp_buf (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ecg_drle_pkg::rsp_push_type push,
   output logic                            in_ready,
   ecg_drle_rsp_if.source                  rsp_ch
);
   import ecg_drle_pkg::*;

   logic         out_valid_ff,  out_valid_in;
   rsp_word_type out_word_ff,   out_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff,  skid_word_in;
   logic         pop;

   assign pop      = out_valid_ff && rsp_ch.ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = push.valid;
            skid_word_in  = push.word;
         end else begin
            out_valid_in = push.valid;
            out_word_in  = push.word;
         end
      end else if (push.valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sample     = out_word_ff.sample;
   assign rsp_ch.repeat_res = out_word_ff.repeat_res;
   assign rsp_ch.stream_end = out_word_ff.stream_end;
   assign rsp_ch.truncated  = out_word_ff.truncated;

endmodule

`default_nettype wire

FILE: design/ecg_delta_rle_stream_decoder.sv
// ----------------------------------------------------------------------------
// ECG delta / run-length stream decoder; each result word leaves from a register.
// 1 bit per cycle until the skid entry fills; a stalled result is parked in it.
// Synchronous reset restores default registers and starts a new stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ecg_delta_rle_stream_decoder_assert.svh"

module ecg_delta_rle_stream_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   ecg_drle_req_if.sink    req_ch,
   ecg_drle_rsp_if.source  rsp_ch,
   ecg_drle_csr_if.sink    csr_ch
);
   import ecg_drle_pkg::*;

   // The stream format is a base (designated) sample, a scaled sample, and then
   // signed tokens. A token equal to the flag value announces another scaled
   // sample; any other token is an error relative to the last reference. In
   // lossy mode every error is followed by a run count that goes out as the
   // repeat field of the same word. Each field is collected, one bit per cycle
   // when not stalled, in a shift register; the decode of a completed field is a
   // short adder and compare in front of the result register.

   cfg_type      cfg_ff, cfg_in;
   rsp_push_type push;
   logic         buf_ready;
   logic         accept;

   // Configuration writes are always taken; unknown indexes are ignored.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            CSR_BITS_ORIGINAL:  cfg_in.bits_original  = csr_ch.wr_data[CFG_WW-1:0];
            CSR_BITS_SCALED:    cfg_in.bits_scaled    = csr_ch.wr_data[CFG_WW-1:0];
            CSR_BITS_THRESHOLD: cfg_in.bits_threshold = csr_ch.wr_data[CFG_WW-1:0];
            CSR_LOSSY_ENABLED:  cfg_in.lossy_enabled  = csr_ch.wr_data[0];
            CSR_FLAG_VALUE:     cfg_in.flag_value     = $signed(csr_ch.wr_data[FLAG_W-1:0]);
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{bits_original:  BITS_ORIGINAL_RST,
                     bits_scaled:    BITS_SCALED_RST,
                     bits_threshold: BITS_THRESHOLD_RST,
                     lossy_enabled:  1'b0,
                     flag_value:     FLAG_VALUE_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A bit is taken whenever the skid entry is free, even with a result waiting.
   assign req_ch.ready = buf_ready;
   assign accept       = req_ch.valid && buf_ready;

   ecg_drle_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .bit_req (req_ch.bit_req),
      .last    (req_ch.last),
      .cfg     (cfg_ff),
      .push    (push)
   );

   ecg_drle_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .in_ready (buf_ready),
      .rsp_ch   (rsp_ch)
   );

   // A truncated word always closes the stream and carries no sample.
   `ECG_DRLE_ASSERT_NOW(a_trunc_word, clock, reset, rsp_ch.valid && rsp_ch.truncated,
      rsp_ch.stream_end && rsp_ch.sample == '0 && rsp_ch.repeat_res == '0,
      "truncated result word is not an empty end-of-stream word")

   // A decoded sample always repeats at least once.
   `ECG_DRLE_ASSERT_NOW(a_repeat_nonzero, clock, reset, rsp_ch.valid && !rsp_ch.truncated,
      rsp_ch.repeat_res != '0, "decoded sample with zero repeat count")

   // Input stalls only happen with a result word waiting at the output.
   `ECG_DRLE_ASSERT_NOW(a_stall_cause, clock, reset, !req_ch.ready,
      rsp_ch.valid, "input stalled with no result pending")

   // After the parser produces a word, a result word is valid in the next cycle.
   `ECG_DRLE_ASSERT_NEXT(a_push_visible, clock, reset, push.valid,
      rsp_ch.valid, "parser result lost before the output register")

endmodule

`default_nettype wire

FILE: tb/ecg_delta_rle_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG delta / run-length stream decoder testbench
// Feeds packed ECG bit streams, one bit per word, under a series of register
// settings and handshake pressure. An in-bench decoder model predicts every
// sample word, and each word the block returns is checked field by field.
// ----------------------------------------------------------------------------

module ecg_delta_rle_stream_decoder_tb;
   import ecg_drle_pkg::*;

   // Tracks the decoder's stream state and holds the sample words it owes.
   class sample_book;
      typedef enum {SEEK_DESIG, SEEK_FIRST, SEEK_TOKEN, SEEK_SCALED, SEEK_COUNT} seek_type;

      cfg_type      regs;
      seek_type     seek;
      logic [15:0]  shifter;
      int           nbits;
      logic [15:0]  designated;
      logic [17:0]  reference;
      logic [15:0]  held_error;
      rsp_word_type owed[$];

      function new();
         regs.bits_original  = BITS_ORIGINAL_RST;
         regs.bits_scaled    = BITS_SCALED_RST;
         regs.bits_threshold = BITS_THRESHOLD_RST;
         regs.lossy_enabled  = 1'b0;
         regs.flag_value     = FLAG_VALUE_RST;
         restart();
      endfunction

      // A width register of zero means one bit; anything wider saturates.
      static function int field_width(logic [CFG_WW-1:0] r);
         if (r == 0) return 1;
         if (int'(r) > MAX_FIELD_BITS) return MAX_FIELD_BITS;
         return int'(r);
      endfunction

      static function int signed_field(logic [15:0] v, int w);
         int x;
         x = int'(v) & ((1 << w) - 1);
         if (x[w-1]) x = x - (1 << w);
         return x;
      endfunction

      function void restart();
         seek       = SEEK_DESIG;
         shifter    = '0;
         nbits      = 0;
         designated = '0;
         reference  = '0;
         held_error = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BITS_ORIGINAL:  regs.bits_original  = data[CFG_WW-1:0];
            CSR_BITS_SCALED:    regs.bits_scaled    = data[CFG_WW-1:0];
            CSR_BITS_THRESHOLD: regs.bits_threshold = data[CFG_WW-1:0];
            CSR_LOSSY_ENABLED:  regs.lossy_enabled  = data[0];
            CSR_FLAG_VALUE:     regs.flag_value     = data;
            default: ;
         endcase
      endfunction

      function void post_sample(int s, int rep, bit fin, bit cut);
         rsp_word_type word;
         word.sample     = SAMPLE_W'(s);
         word.repeat_res = REPEAT_W'(rep);
         word.stream_end = fin;
         word.truncated  = cut;
         owed = {owed, word};
         if (fin) restart();
      endfunction

      // One accepted stream bit; queues the sample word it completes, if any.
      function void note_bit(bit b, bit l);
         int          w;
         int          tok;
         int          rep;
         logic [15:0] val;
         case (seek)
            SEEK_FIRST, SEEK_SCALED: w = field_width(regs.bits_scaled);
            SEEK_TOKEN, SEEK_COUNT:  w = field_width(regs.bits_threshold);
            default:                 w = field_width(regs.bits_original);
         endcase
         shifter = {shifter[14:0], b};
         nbits++;
         if (nbits < w) begin
            if (l) post_sample(0, 0, 1'b1, 1'b1);
            return;
         end
         val     = shifter & 16'((32'd1 << w) - 1);
         shifter = '0;
         nbits   = 0;
         case (seek)
            SEEK_DESIG: begin
               designated = val;
               seek = SEEK_FIRST;
               if (l) post_sample(0, 0, 1'b1, 1'b1);
            end
            SEEK_FIRST, SEEK_SCALED: begin
               reference = 18'(val) + 18'(designated);
               seek = SEEK_TOKEN;
               post_sample(int'(reference), 1, l, 1'b0);
            end
            SEEK_TOKEN: begin
               tok = signed_field(val, w);
               if (tok == int'($signed(regs.flag_value))) begin
                  seek = SEEK_SCALED;
                  if (l) post_sample(0, 0, 1'b1, 1'b1);
               end else if (regs.lossy_enabled) begin
                  held_error = tok[15:0];
                  seek = SEEK_COUNT;
                  if (l) post_sample(0, 0, 1'b1, 1'b1);
               end else begin
                  post_sample(int'(reference) + tok, 1, l, 1'b0);
               end
            end
            default: begin
               rep = (val == 0) ? (1 << w) : int'(val);
               tok = signed_field(held_error, 16);
               held_error = '0;
               seek = SEEK_TOKEN;
               post_sample(int'(reference) + tok, rep, l, 1'b0);
            end
         endcase
      endfunction

      // Returns an empty string when the word matches the oldest one owed.
      function string check_sample(rsp_word_type got);
         rsp_word_type want;
         string        why;
         why = "";
         if (owed.size() == 0)
            return $sformatf("unexpected sample %0d repeat %0d end %0b trunc %0b",
                             got.sample, got.repeat_res, got.stream_end, got.truncated);
         want = owed.pop_front();
         if (got.sample !== want.sample)
            why = {why, $sformatf(" sample %0d/%0d", got.sample, want.sample)};
         if (got.repeat_res !== want.repeat_res)
            why = {why, $sformatf(" repeat %0d/%0d", got.repeat_res, want.repeat_res)};
         if (got.stream_end !== want.stream_end)
            why = {why, $sformatf(" stream_end %0b/%0b", got.stream_end, want.stream_end)};
         if (got.truncated !== want.truncated)
            why = {why, $sformatf(" truncated %0b/%0b", got.truncated, want.truncated)};
         if (why != "") why = {"got/expected:", why};
         return why;
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   typedef struct {
      bit b;
      bit l;
   } stream_bit_type;

   // Index that decodes to no register; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = CSR_IDX_W'(7);

   localparam int ITEMS         = 1650;
   localparam int PHASES        = 12;
   localparam int PHASE_BITS    = (ITEMS - 25) / PHASES;
   localparam int MIN_SAMPLES   = 48;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 3000;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;

   logic clock;
   logic reset;

   ecg_drle_req_if req_bus ();
   ecg_drle_rsp_if rsp_bus ();
   ecg_drle_csr_if csr_bus ();

   ecg_delta_rle_stream_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   sample_book     book = new();
   stream_bit_type stream_bits[$];
   cfg_type        plan_cfg;
   int             req_idle_pct;
   int             rsp_stall_pct;
   int             hold_requests;
   int             hold_served;
   int             hold_left;
   int             mismatch_count;
   int             samples_seen;
   int             quiet_cycles;

   always #10 clock = ~clock;

   // Every mismatch lands here. Printing stops after a couple of hundred lines
   // so that a badly broken block cannot flood the log, but counting goes on.
   task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 200) $display("mismatch at %0t:%s", $time, what);
   endtask

   // All three channels are sampled at the rising edge, before any of the
   // nonblocking updates of that edge land, so the order of processes within
   // the step does not matter. The bit is noted before the result is checked
   // in case the block ever answers in the same cycle.
   always @(posedge clock) begin
      rsp_word_type got;
      string        why;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) book.set_reg(csr_bus.reg_index, csr_bus.wr_data);
         if (req_bus.valid && req_bus.ready) book.note_bit(req_bus.bit_req, req_bus.last);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.sample     = rsp_bus.sample;
            got.repeat_res = rsp_bus.repeat_res;
            got.stream_end = rsp_bus.stream_end;
            got.truncated  = rsp_bus.truncated;
            samples_seen++;
            why = book.check_sample(got);
            if (why != "") report_mismatch(why);
         end
      end
   end

   // Receiver side. A hold request from the main flow forces ready low for a
   // long stretch while the sender keeps offering bits, which fills the
   // block's result buffer and must back-pressure the bit input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
      end
   end

   // Watchdog: a run that stops moving words on every channel is a failure.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ecg_delta_rle_stream_decoder_tb: FAIL");
         $finish;
      end
   end

   // Offers one bit and returns at the edge that accepts it. Valid stays high
   // on return so that back-to-back bits go out without a bubble.
   task send_bit(bit b, bit l);
      while (int'($urandom_range(99)) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.bit_req <= b;
      req_bus.last    <= l;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data   <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // Writes all five registers. Unused upper data bits are sometimes set, as
   // the block must ignore them; now and then a write to an unmapped index
   // goes along too.
   task program_config(cfg_type c);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom_range(1) ? CSR_DATA_W'($urandom) : '0;
      csr_put(CSR_BITS_ORIGINAL,  {junk[15:5], c.bits_original});
      csr_put(CSR_BITS_SCALED,    {junk[15:5], c.bits_scaled});
      csr_put(CSR_BITS_THRESHOLD, {junk[15:5], c.bits_threshold});
      csr_put(CSR_LOSSY_ENABLED,  {junk[15:1], c.lossy_enabled});
      csr_put(CSR_FLAG_VALUE,     c.flag_value);
      if ($urandom_range(3) == 0) csr_put(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      csr_bus.valid <= 1'b0;
      plan_cfg = c;
   endtask

   // Stops sending and waits until every owed sample word is back, then lets
   // a bit that completed no word yet settle, so registers can be written.
   task settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function void add_field(int v, int w);
      stream_bit_type sb;
      for (int i = w - 1; i >= 0; i--) begin
         sb.b = v[i];
         sb.l = 1'b0;
         stream_bits = {stream_bits, sb};
      end
   endfunction

   function void close_stream();
      stream_bits[stream_bits.size() - 1].l = 1'b1;
   endfunction

   function int pick_plain(int w);
      int top;
      top = (1 << w) - 1;
      case ($urandom_range(7))
         0: return 0;
         1: return top;
         default: return int'($urandom_range(top));
      endcase
   endfunction

   function int pick_error(int w);
      int half;
      half = 1 << (w - 1);
      case ($urandom_range(7))
         0: return -half;
         1: return half - 1;
         2: return 0;
         3: return -1;
         default: return -half + int'($urandom_range(2 * half - 1));
      endcase
   endfunction

   // A run count whose bit pattern equals the flag must still be a count.
   function int pick_count(int w, int flag_i);
      case ($urandom_range(7))
         0: return 0;
         1: return flag_i & ((1 << w) - 1);
         default: return pick_plain(w);
      endcase
   endfunction

   // Plans one stream under the current settings. Most streams are well
   // formed: designated sample, first scaled sample, then a mix of flags with
   // fresh scaled samples and error tokens (with counts in lossy mode), ending
   // on a bit that completes a sample. About a quarter are cut at a random bit
   // so that the stream ends inside a field or after a field that needs a
   // follower, and a few are plain noise.
   function void plan_stream();
      int wo;
      int ws;
      int wt;
      int half;
      int flag_i;
      int tok;
      int start;
      int cut;
      bit fits;
      start = stream_bits.size();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(40, 1)) add_field(int'($urandom_range(1)), 1);
         close_stream();
         return;
      end
      wo     = sample_book::field_width(plan_cfg.bits_original);
      ws     = sample_book::field_width(plan_cfg.bits_scaled);
      wt     = sample_book::field_width(plan_cfg.bits_threshold);
      half   = 1 << (wt - 1);
      flag_i = int'($signed(plan_cfg.flag_value));
      fits   = (flag_i >= -half) && (flag_i < half);
      add_field(pick_plain(wo), wo);
      add_field(pick_plain(ws), ws);
      repeat ($urandom_range(12, 1)) begin
         if (fits && $urandom_range(4) == 0) begin
            add_field(flag_i, wt);
            add_field(pick_plain(ws), ws);
         end else begin
            do tok = pick_error(wt); while (fits && tok == flag_i);
            add_field(tok, wt);
            if (plan_cfg.lossy_enabled) add_field(pick_count(wt, flag_i), wt);
         end
      end
      if ($urandom_range(3) == 0) begin
         cut = int'($urandom_range(stream_bits.size() - 1, start));
         while (stream_bits.size() > cut + 1) void'(stream_bits.pop_back());
      end
      close_stream();
   endfunction

   // Sends a number of bits, planning streams as needed. A stream left
   // unfinished at the end of a phase carries over into the next one, so its
   // remaining bits are decoded under new settings, in mid-field at times.
   task run_bits(int budget);
      stream_bit_type sb;
      for (int n = 0; n < budget; n++) begin
         if (stream_bits.size() == 0) plan_stream();
         sb = stream_bits.pop_front();
         send_bit(sb.b, sb.l);
      end
   endtask

   function logic [CFG_WW-1:0] pick_width_reg(int lo, bit small_only);
      if (small_only) return CFG_WW'($urandom_range(6, lo));
      case ($urandom_range(9))
         0: return '0;
         1: return CFG_WW'($urandom_range(31, 17));
         2: return CFG_WW'(MAX_FIELD_BITS);
         default: return CFG_WW'($urandom_range(6, lo));
      endcase
   endfunction

   // Flags mostly fall inside the token range; the rest are extreme or random
   // values that often lie outside it.
   function cfg_type random_cfg(bit small_only);
      cfg_type c;
      int      half;
      c.bits_original  = pick_width_reg(1, small_only);
      c.bits_scaled    = pick_width_reg(1, small_only);
      c.bits_threshold = pick_width_reg(2, small_only);
      c.lossy_enabled  = 1'($urandom_range(1));
      half = 1 << (sample_book::field_width(c.bits_threshold) - 1);
      case ($urandom_range(9))
         0: c.flag_value = 16'h8000;
         1: c.flag_value = 16'h7fff;
         2, 3: c.flag_value = 16'($urandom);
         default: c.flag_value = 16'(-half + int'($urandom_range(2 * half - 1)));
      endcase
      return c;
   endfunction

   initial begin
      cfg_type c;
      int      spins;
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.bit_req   = 1'b0;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = '0;
      csr_bus.wr_data   = '0;
      req_idle_pct      = 0;
      rsp_stall_pct     = 0;
      hold_requests     = 0;
      hold_served       = 0;
      hold_left         = 0;
      mismatch_count    = 0;
      samples_seen      = 0;
      quiet_cycles      = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed streams on the narrowest settings: a designated width of
      // zero (decoded as one bit), one-bit scaled samples, two-bit tokens,
      // lossy mode and a flag of one.
      c = '{bits_original: 5'd0, bits_scaled: 5'd1, bits_threshold: 5'd2,
            lossy_enabled: 1'b1, flag_value: 16'sd1};
      program_config(c);
      // Full stream: samples 2 and 1, a run of four zeros from a count of
      // zero, then -1 closed by a count whose pattern equals the flag.
      add_field(1, 1);
      add_field(1, 1);
      add_field(1, 2);
      add_field(0, 1);
      add_field(-1, 2);
      add_field(0, 2);
      add_field(-2, 2);
      add_field(1, 2);
      close_stream();
      // Stream ending right after the designated sample.
      add_field(0, 1);
      close_stream();
      // Stream ending inside a token.
      add_field(1, 1);
      add_field(0, 1);
      add_field(1, 1);
      close_stream();
      // Stream ending on a flag.
      add_field(1, 1);
      add_field(1, 1);
      add_field(1, 2);
      close_stream();
      // Stream ending on an error that still waits for its count.
      add_field(1, 1);
      add_field(1, 1);
      add_field(-1, 2);
      close_stream();
      run_bits(stream_bits.size());
      settle();

      // Random phases. The handshake pattern cycles through no idling, an idle
      // sender, a stalling receiver and both at once. The first two phases pin
      // the extremes: widest fields in lossy mode, then narrowest fields with
      // a flag outside the token range. Two phases with an eager sender also
      // hold the receiver off for a long stretch. Extra phases on small
      // widths follow if too few sample words came back.
      for (int p = 0; p < PHASES || (samples_seen < MIN_SAMPLES && p < PHASES + 8); p++) begin
         case (p)
            0: c = '{bits_original: 5'd16, bits_scaled: 5'd16, bits_threshold: 5'd16,
                     lossy_enabled: 1'b1, flag_value: 16'sh7fff};
            1: c = '{bits_original: 5'd1, bits_scaled: 5'd1, bits_threshold: 5'd2,
                     lossy_enabled: 1'b0, flag_value: 16'sh8000};
            default: c = random_cfg(p >= PHASES || p % 4 == 0);
         endcase
         program_config(c);
         case (p % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 70;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 70;
            end
            default: begin
               req_idle_pct  = 34;
               rsp_stall_pct = 34;
            end
         endcase
         if (p == 4 || p == 8) hold_requests++;
         run_bits(PHASE_BITS);
         settle();
      end

      // Send whatever is left of the last planned stream, then drain.
      run_bits(stream_bits.size());
      req_bus.valid <= 1'b0;
      @(posedge clock);
      spins = 0;
      while (book.pending() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.pending() != 0)
         report_mismatch($sformatf(" %0d sample words never arrived", book.pending()));
      if (mismatch_count == 0) begin
         $display("ecg_delta_rle_stream_decoder_tb: PASS");
      end else begin
         $display("ecg_delta_rle_stream_decoder_tb: FAIL");
      end
      $finish;
   end

endmodule
